// ===== src/unicycle_pose_integrator_assert.svh =====
// assertion macros used by the pose integrator
`ifndef UNICYCLE_POSE_INTEGRATOR_ASSERT_SVH
`define UNICYCLE_POSE_INTEGRATOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define UPI_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define UPI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/upi_pkg.sv =====
// ----------------------------------------------------------------------------
// upi_pkg
// types, constants and the arctangent table of the unicycle pose integrator
// ----------------------------------------------------------------------------
`default_nettype none

package upi_pkg;

    // cordic configuration
    localparam int CORDIC_ROUNDS = 16;
    localparam int ATAN_ENTRIES  = 24;
    localparam int CORDIC_N      = (CORDIC_ROUNDS > ATAN_ENTRIES) ? ATAN_ENTRIES
                                                                 : CORDIC_ROUNDS;
    localparam int RND_W         = (CORDIC_N > 1) ? $clog2(CORDIC_N) : 1;
    localparam int CW            = 32;   // q2.30 vector width
    localparam int ZW            = 26;   // residual angle, 2^-24 turn units
    localparam logic signed [CW-1:0] CORDIC_START = 32'sd652032874;

    // register reset values
    localparam logic [15:0] TIME_STEP_RST  = 16'd6554;
    localparam logic [15:0] STEP_LIMIT_RST = 16'd50;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIME_STEP     = 3'd0,
        CFG_STEP_LIMIT    = 3'd1,
        CFG_START_X       = 3'd2,
        CFG_START_Y       = 3'd3,
        CFG_START_HEADING = 3'd4
    } t_cfg_idx;

    // command codes
    localparam logic CMD_ADVANCE = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_VDT,
        S_HDT,
        S_HUPD,
        S_WAIT,
        S_MX,
        S_MY,
        S_ADDY,
        S_DONE
    } t_state;

    // cordic request and result
    typedef struct packed {
        logic        start;
        logic [15:0] angle;
    } t_cordic_req;

    typedef struct packed {
        logic                 ready;
        logic signed [CW-1:0] cos_val;
        logic signed [CW-1:0] sin_val;
    } t_cordic_res;

    // atan(2^-i) in 2^-24 turn
    function automatic logic signed [ZW-1:0] atan_lookup(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0:    v = 26'sd2097152;
            5'd1:    v = 26'sd1238021;
            5'd2:    v = 26'sd654136;
            5'd3:    v = 26'sd332050;
            5'd4:    v = 26'sd166669;
            5'd5:    v = 26'sd83416;
            5'd6:    v = 26'sd41718;
            5'd7:    v = 26'sd20860;
            5'd8:    v = 26'sd10430;
            5'd9:    v = 26'sd5215;
            5'd10:   v = 26'sd2608;
            5'd11:   v = 26'sd1304;
            5'd12:   v = 26'sd652;
            5'd13:   v = 26'sd326;
            5'd14:   v = 26'sd163;
            5'd15:   v = 26'sd81;
            5'd16:   v = 26'sd41;
            5'd17:   v = 26'sd20;
            5'd18:   v = 26'sd10;
            5'd19:   v = 26'sd5;
            5'd20:   v = 26'sd3;
            5'd21:   v = 26'sd1;
            5'd22:   v = 26'sd1;
            default: v = 26'sd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== src/upi_cordic.sv =====
// ----------------------------------------------------------------------------
// upi_cordic
// iterative rotation-mode cordic, one round per cycle, gives cos and sin
// ----------------------------------------------------------------------------
`default_nettype none

module upi_cordic
    import upi_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cordic_req i_req,
    output t_cordic_res      o_res
);

    logic                 r_busy;
    logic                 r_ready;
    logic                 r_flip;
    logic [RND_W-1:0]     r_round;
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [ZW-1:0] r_z;

    logic signed [16:0]   a_raw;
    logic signed [16:0]   a_fold;
    logic                 fold;
    logic signed [ZW-1:0] z_init;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [ZW-1:0] at;
    logic                 last_round;

    // fold heading into a quarter turn either side of zero
    always_comb begin
        a_raw = {i_req.angle[15], i_req.angle};
        fold  = 1'b0;
        a_fold = a_raw;
        if (a_raw > 17'sd16384) begin
            a_fold = a_raw - 17'sd32768;
            fold   = 1'b1;
        end else if (a_raw < -17'sd16384) begin
            a_fold = a_raw + 17'sd32768;
            fold   = 1'b1;
        end
        z_init = {{(ZW-25){a_fold[16]}}, a_fold, 8'b0};
    end

    // shared shift and table step of one round
    assign dx         = r_y >>> r_round;
    assign dy         = r_x >>> r_round;
    assign at         = atan_lookup(5'(r_round));
    assign last_round = (r_round == RND_W'(CORDIC_N - 1));

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_ready <= 1'b0;
            r_round <= '0;
        end else if (i_req.start) begin
            r_busy  <= 1'b1;
            r_ready <= 1'b0;
            r_round <= '0;
        end else if (r_busy) begin
            r_round <= r_round + 1'b1;
            if (last_round) begin
                r_busy  <= 1'b0;
                r_ready <= 1'b1;
            end
        end
    end

    // vector and residual angle
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x    <= CORDIC_START;
            r_y    <= '0;
            r_z    <= z_init;
            r_flip <= fold;
        end else if (r_busy) begin
            if (r_z >= 0) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + at;
            end
        end
    end

    // undo the half-turn fold
    assign o_res.ready   = r_ready;
    assign o_res.cos_val = r_flip ? -r_x : r_x;
    assign o_res.sin_val = r_flip ? -r_y : r_y;

endmodule

`default_nettype wire

// ===== src/unicycle_pose_integrator.sv =====
// ----------------------------------------------------------------------------
// unicycle_pose_integrator
// forward euler dead reckoning of x, y and heading for a unicycle model
// ----------------------------------------------------------------------------
// input channel: i_in_valid / o_in_stall, beat carries cmd, speed, turn_rate
// output channel: o_out_valid / i_out_stall, one beat per input beat with
//   the pose, step count and finished flag after that item
// config channel: i_cfg_valid / o_cfg_ready, index 0 time_step, 1 step_limit,
//   2 start_x, 3 start_y, 4 start_heading; other indexes are dropped
// an advance beat runs the iterative cordic, one round per cycle, followed
//   by two passes through the shared 32x32 multiplier and the saturating adder
// restart beats and beats past the step limit go straight to the done state
// the block takes one beat at a time; o_in_stall is high while it works
// a result held by i_out_stall does not block the next input beat, but the
//   following result waits in the sequencer until the output register frees
// reset clears pose and step count and loads the config reset values; the
//   start pose is only loaded by a restart command
// ----------------------------------------------------------------------------
`default_nettype none

module unicycle_pose_integrator
    import upi_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // input channel
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic                 i_cmd,
    input  wire logic signed [15:0]   i_speed,
    input  wire logic signed [23:0]   i_turn_rate,
    // output channel
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic signed [31:0]        o_pos_x,
    output logic signed [31:0]        o_pos_y,
    output logic [15:0]               o_heading,
    output logic [15:0]               o_steps_done,
    output logic                      o_finished,
    // config channel
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]          i_cfg_data
);

`include "unicycle_pose_integrator_assert.svh"

    // config registers
    logic [15:0]        r_time_step;
    logic [15:0]        r_step_limit;
    logic signed [31:0] r_start_x;
    logic signed [31:0] r_start_y;
    logic [15:0]        r_start_heading;

    // pose state
    logic signed [31:0] r_cur_x;
    logic signed [31:0] r_cur_y;
    logic [15:0]        r_cur_heading;
    logic [15:0]        r_step_count;
    logic               r_fin;

    // working registers
    t_state             r_state;
    t_state             n_state;
    logic signed [15:0] r_speed;
    logic signed [23:0] r_turn;
    logic signed [31:0] r_vdt;
    logic signed [63:0] r_prod;
    logic               r_out_valid;

    logic               in_acc;
    logic               out_free;
    logic               limit_hit;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] prod;
    logic signed [63:0] prod_rnd;
    logic signed [32:0] pos_sum;
    logic signed [31:0] pos_base;
    logic signed [31:0] pos_sat;
    logic [31:0]        hdg_rnd;
    t_cordic_req        cordic_req;
    t_cordic_res        cordic_res;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign limit_hit = (r_step_count >= r_step_limit);

    // config writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step     <= TIME_STEP_RST;
            r_step_limit    <= STEP_LIMIT_RST;
            r_start_x       <= '0;
            r_start_y       <= '0;
            r_start_heading <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TIME_STEP:     r_time_step     <= i_cfg_data[15:0];
                CFG_STEP_LIMIT:    r_step_limit    <= i_cfg_data[15:0];
                CFG_START_X:       r_start_x       <= i_cfg_data;
                CFG_START_Y:       r_start_y       <= i_cfg_data;
                CFG_START_HEADING: r_start_heading <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // cordic on the heading from before the step
    assign cordic_req.start = in_acc && (i_cmd == CMD_ADVANCE) && !limit_hit;
    assign cordic_req.angle = r_cur_heading;

    upi_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cordic_req),
        .o_res   (cordic_res)
    );

    // shared multiplier operand select
    always_comb begin
        mul_a = 32'(signed'({1'b0, r_time_step}));
        mul_b = 32'(r_speed);
        case (r_state)
            S_HDT: begin
                mul_b = 32'(r_turn);
            end
            S_MX: begin
                mul_a = r_vdt;
                mul_b = cordic_res.cos_val;
            end
            S_MY: begin
                mul_a = r_vdt;
                mul_b = cordic_res.sin_val;
            end
            default: ;
        endcase
    end

    assign prod = mul_a * mul_b;

    // round q10.54 to q16.16 and add with saturation
    assign prod_rnd = r_prod + 64'sd137438953472;
    assign pos_base = (r_state == S_MY) ? r_cur_x : r_cur_y;
    assign pos_sum  = {pos_base[31], pos_base} + {{7{prod_rnd[63]}}, prod_rnd[63:38]};

    always_comb begin
        pos_sat = pos_sum[31:0];
        if (pos_sum[32] != pos_sum[31]) begin
            pos_sat = pos_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
    end

    // heading increment rounded half up
    assign hdg_rnd = r_prod[31:0] + 32'd32768;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and handshake outputs
    always_comb begin
        n_state    = r_state;
        o_in_stall = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_cmd == CMD_RESTART || limit_hit) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_VDT;
                    end
                end
            end
            S_VDT:  n_state = S_HDT;
            S_HDT:  n_state = S_HUPD;
            S_HUPD: n_state = S_WAIT;
            S_WAIT: begin
                if (cordic_res.ready) begin
                    n_state = S_MX;
                end
            end
            S_MX:   n_state = S_MY;
            S_MY:   n_state = S_ADDY;
            S_ADDY: n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // pose state and step count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x       <= '0;
            r_cur_y       <= '0;
            r_cur_heading <= '0;
            r_step_count  <= '0;
            r_fin         <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_fin <= 1'b0;
                        if (i_cmd == CMD_RESTART) begin
                            r_cur_x       <= r_start_x;
                            r_cur_y       <= r_start_y;
                            r_cur_heading <= r_start_heading;
                            r_step_count  <= '0;
                        end else if (limit_hit) begin
                            r_fin <= 1'b1;
                        end
                    end
                end
                S_HUPD: r_cur_heading <= r_cur_heading + hdg_rnd[31:16];
                S_MY:   r_cur_x       <= pos_sat;
                S_ADDY: begin
                    r_cur_y      <= pos_sat;
                    r_step_count <= r_step_count + 16'd1;
                end
                default: ;
            endcase
        end
    end

    // operands and products
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_speed <= i_speed;
            r_turn  <= i_turn_rate;
        end
        if (r_state == S_HDT) begin
            r_vdt <= r_prod[31:0];
        end
        r_prod <= prod;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            o_pos_x      <= r_cur_x;
            o_pos_y      <= r_cur_y;
            o_heading    <= r_cur_heading;
            o_steps_done <= r_step_count;
            o_finished   <= r_fin;
        end
    end

    assign o_out_valid = r_out_valid;

    // checks
    `UPI_ASSERT_NEXT(a_step_inc, i_clk, i_rst_n, r_state == S_ADDY,
        r_step_count == 16'($past(r_step_count) + 16'd1), "step count did not advance")
    `UPI_ASSERT_NEXT(a_ignored_tick, i_clk, i_rst_n,
        in_acc && i_cmd == CMD_ADVANCE && limit_hit,
        r_fin && r_state == S_DONE && $stable(r_cur_x) && $stable(r_cur_y),
        "tick past the limit changed the pose")
    `UPI_ASSERT_NOW(a_out_load, i_clk, i_rst_n, $rose(r_out_valid),
        $past(r_state) == S_DONE, "result loaded outside completion")
    `UPI_ASSERT_NOW(a_cordic_idle, i_clk, i_rst_n, r_state == S_MX || r_state == S_MY,
        cordic_res.ready, "products taken before cordic finished")

endmodule

`default_nettype wire

// ===== tb/pose_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pose_checker
// watches the config, tick and pose channels of the pose integrator, keeps
// its own copy of the registers and the pose, works out the pose each
// accepted tick beat should produce and compares it with the pose beats
// ----------------------------------------------------------------------------

module pose_checker
    import upi_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // tick channel
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic                 i_cmd,
    input  logic signed [15:0]   i_speed,
    input  logic signed [23:0]   i_turn_rate,
    // pose channel
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic signed [31:0]   i_pos_x,
    input  logic signed [31:0]   i_pos_y,
    input  logic [15:0]          i_heading,
    input  logic [15:0]          i_steps_done,
    input  logic                 i_finished,
    // config channel
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    // status to the top
    output int                   o_pending,
    output int                   o_fail_count
);

    localparam int ROTATIONS = (CORDIC_ROUNDS > 24) ? 24 : CORDIC_ROUNDS;
    localparam longint UNIT_VEC = 64'sd652032874;
    localparam longint HALF_LSB = 64'sd137438953472;   // half of 2^38
    localparam longint POS_TOP  = 64'sd2147483647;
    localparam longint POS_BOT  = -64'sd2147483648;

    // arctangent of 2^-i in 2^-24 turn
    localparam longint ATAN_TURN [0:23] = '{
        2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
        10430, 5215, 2608, 1304, 652, 326, 163, 81,
        41, 20, 10, 5, 3, 1, 1, 0
    };

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [15:0]        hdg;
        logic [15:0]        steps;
        logic               fin;
    } t_pose_beat;

    // register copy
    logic [15:0]        dt_q16;
    logic [15:0]        step_lim;
    logic signed [31:0] home_x;
    logic signed [31:0] home_y;
    logic [15:0]        home_hdg;

    // pose copy
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic [15:0]        pose_hdg;
    logic [15:0]        step_cnt;

    t_pose_beat expected_poses[$];
    int         fail_total = 0;

    assign o_fail_count = fail_total;

    function automatic logic signed [31:0] sat32(input longint v);
        if (v > POS_TOP) return POS_TOP[31:0];
        if (v < POS_BOT) return POS_BOT[31:0];
        return v[31:0];
    endfunction

    // rotation-mode cordic: unit vector at the heading, q2.30
    function automatic void rotate_heading(input logic [15:0] ang,
                                           output longint cos_q,
                                           output longint sin_q);
        longint a, vx, vy, z, sx, sy;
        bit     fold;
        a    = longint'($signed(ang));
        fold = 1'b0;
        vx   = UNIT_VEC;
        vy   = 0;
        // fold into the right half plane by a half turn
        if (a > 16384) begin
            a    = a - 32768;
            fold = 1'b1;
        end else if (a < -16384) begin
            a    = a + 32768;
            fold = 1'b1;
        end
        z = a * 256;
        for (int i = 0; i < ROTATIONS; i++) begin
            sx = vy >>> i;
            sy = vx >>> i;
            if (z >= 0) begin
                vx = vx - sx;
                vy = vy + sy;
                z  = z - ATAN_TURN[i];
            end else begin
                vx = vx + sx;
                vy = vy - sy;
                z  = z + ATAN_TURN[i];
            end
        end
        cos_q = fold ? -vx : vx;
        sin_q = fold ? -vy : vy;
    endfunction

    // next pose for one tick beat, queued as the expected pose beat
    task automatic predict_pose(input logic cmd, input logic signed [15:0] spd,
                                input logic signed [23:0] rate);
        t_pose_beat want;
        longint     vdt, cv, sv, turn_sum;
        want.fin = 1'b0;
        if (cmd == CMD_RESTART) begin
            pose_x   = home_x;
            pose_y   = home_y;
            pose_hdg = home_hdg;
            step_cnt = '0;
        end else if (step_cnt >= step_lim) begin
            want.fin = 1'b1;
        end else begin
            // move along the heading from before the step
            vdt = longint'(spd) * longint'(dt_q16);
            rotate_heading(pose_hdg, cv, sv);
            pose_x   = sat32(longint'(pose_x) + ((vdt * cv + HALF_LSB) >>> 38));
            pose_y   = sat32(longint'(pose_y) + ((vdt * sv + HALF_LSB) >>> 38));
            turn_sum = longint'(rate) * longint'(dt_q16) + 32768;
            pose_hdg = pose_hdg + turn_sum[31:16];
            step_cnt = step_cnt + 16'd1;
        end
        want.x     = pose_x;
        want.y     = pose_y;
        want.hdg   = pose_hdg;
        want.steps = step_cnt;
        expected_poses = {expected_poses, want};
    endtask

    task automatic compare_field(input string tag, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, tag, want, got);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        t_pose_beat want;
        if (!i_rst_n) begin
            dt_q16   = TIME_STEP_RST;
            step_lim = STEP_LIMIT_RST;
            home_x   = '0;
            home_y   = '0;
            home_hdg = '0;
            pose_x   = '0;
            pose_y   = '0;
            pose_hdg = '0;
            step_cnt = '0;
            expected_poses.delete();
            o_pending <= 0;
        end else begin
            // register writes, upper bits dropped
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_TIME_STEP:     dt_q16   = i_cfg_data[15:0];
                    CFG_STEP_LIMIT:    step_lim = i_cfg_data[15:0];
                    CFG_START_X:       home_x   = i_cfg_data;
                    CFG_START_Y:       home_y   = i_cfg_data;
                    CFG_START_HEADING: home_hdg = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            // pose beat against the oldest expectation
            if (i_out_valid && !i_out_stall) begin
                if (expected_poses.size() == 0) begin
                    $display("%0t: pose beat with nothing expected, actual %h %h %h %h %b",
                             $time, i_pos_x, i_pos_y, i_heading, i_steps_done, i_finished);
                    fail_total++;
                end else begin
                    want = expected_poses.pop_front();
                    compare_field("pos_x", want.x, i_pos_x);
                    compare_field("pos_y", want.y, i_pos_y);
                    compare_field("heading", {16'd0, want.hdg}, {16'd0, i_heading});
                    compare_field("steps_done", {16'd0, want.steps}, {16'd0, i_steps_done});
                    compare_field("finished", {31'd0, want.fin}, {31'd0, i_finished});
                end
            end
            // tick beat
            if (i_in_valid && !i_in_stall)
                predict_pose(i_cmd, i_speed, i_turn_rate);
            o_pending <= expected_poses.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives the pose integrator with directed and random tick beats under
// random register settings, bursty input and a wandering output stall,
// and reports the verdict of the pose checker
// ----------------------------------------------------------------------------

module testbench;
    import upi_pkg::*;

    localparam int RANDOM_ITEMS = 1750;
    localparam int QUIET_LIMIT  = 2000;
    localparam int SETTLE       = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = '1;

    localparam logic signed [15:0] SPEED_MAX = 16'sh7FFF;
    localparam logic signed [15:0] SPEED_MIN = 16'sh8000;
    localparam logic signed [23:0] TURN_MAX  = 24'sh7FFFFF;
    localparam logic signed [23:0] TURN_MIN  = 24'sh800000;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_LONG
    } t_stall_mode;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    logic                 cmd       = CMD_ADVANCE;
    logic signed [15:0]   speed     = '0;
    logic signed [23:0]   turn_rate = '0;

    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic signed [31:0]   pos_x;
    logic signed [31:0]   pos_y;
    logic [15:0]          heading;
    logic [15:0]          steps_done;
    logic                 finished;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data  = '0;

    int pending;
    int fail_count;

    t_stall_mode stall_mode = STALL_NONE;
    int          mode_left  = 0;
    int          hold_left  = 0;
    int          burst_left = 0;
    int          quiet      = 0;

    always #2 clk = ~clk;

    unicycle_pose_integrator u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_cmd       (cmd),
        .i_speed     (speed),
        .i_turn_rate (turn_rate),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_pos_x     (pos_x),
        .o_pos_y     (pos_y),
        .o_heading   (heading),
        .o_steps_done(steps_done),
        .o_finished  (finished),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    pose_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_cmd       (cmd),
        .i_speed     (speed),
        .i_turn_rate (turn_rate),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_pos_x     (pos_x),
        .i_pos_y     (pos_y),
        .i_heading   (heading),
        .i_steps_done(steps_done),
        .i_finished  (finished),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_pending   (pending),
        .o_fail_count(fail_count)
    );

    // output stall: modes of random length, from none to long holds
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_mode <= STALL_NONE;
            mode_left  <= 0;
            hold_left  <= 0;
        end else begin
            if (mode_left == 0) begin
                stall_mode <= t_stall_mode'($urandom_range(0, 3));
                mode_left  <= $urandom_range(16, 400);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                STALL_NONE:  out_stall <= 1'b0;
                STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                default: begin
                    if (hold_left == 0) begin
                        out_stall <= ~out_stall;
                        hold_left <= $urandom_range(1, 30);
                    end else begin
                        hold_left <= hold_left - 1;
                    end
                end
            endcase
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // one tick beat; valid stays up inside a burst, may drop for a gap after it
    task automatic send_tick(input logic c, input logic signed [15:0] spd,
                             input logic signed [23:0] rate);
        int gap;
        in_valid  <= 1'b1;
        cmd       <= c;
        speed     <= spd;
        turn_rate <= rate;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    // stop sending and wait for every expected pose beat
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // full register set, written once the block is idle
    task automatic load_setup(input logic [15:0] dt, input logic [15:0] lim,
                              input logic [31:0] sx, input logic [31:0] sy,
                              input logic [15:0] sh);
        drain();
        write_reg(CFG_TIME_STEP, {16'($urandom), dt});
        write_reg(CFG_STEP_LIMIT, {16'($urandom), lim});
        write_reg(CFG_START_X, sx);
        write_reg(CFG_START_Y, sy);
        write_reg(CFG_START_HEADING, {16'($urandom), sh});
        // unused index, must change nothing
        write_reg(CFG_IDX_SPARE, $urandom);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [15:0] pick_speed();
        case ($urandom_range(0, 7))
            0:       return SPEED_MAX;
            1:       return SPEED_MIN;
            2:       return 16'($urandom_range(0, 1024)) - 16'd512;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [23:0] pick_turn();
        case ($urandom_range(0, 7))
            0:       return TURN_MAX;
            1:       return TURN_MIN;
            2, 3:    return 24'($urandom_range(0, 8000)) - 24'd4000;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_pos();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_step();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'hFFFF;
            default: return 16'($urandom_range(1, 65535));
        endcase
    endfunction

    function automatic logic [15:0] pick_limit();
        case ($urandom_range(0, 19))
            0:                   return 16'd0;
            1:                   return 16'd1;
            2:                   return 16'hFFFF;
            3, 4, 5, 6, 7, 8, 9: return 16'($urandom_range(2, 30));
            default:             return 16'($urandom_range(31, 300));
        endcase
    endfunction

    initial begin
        int n_sent;
        int n_ticks;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset registers, pose starts at zero without a restart
        send_tick(CMD_ADVANCE, SPEED_MAX, TURN_MAX);
        send_tick(CMD_ADVANCE, SPEED_MIN, TURN_MIN);
        send_tick(CMD_ADVANCE, 16'sd0, 24'sd0);
        send_tick(CMD_RESTART, SPEED_MAX, TURN_MAX);

        // full time step near the position edges, both saturation directions
        load_setup(16'hFFFF, 16'd3, 32'h7FFF_8000, 32'h8000_0000, 16'h2000);
        send_tick(CMD_RESTART, 16'sd0, 24'sd0);
        send_tick(CMD_ADVANCE, SPEED_MAX, 24'sd0);
        send_tick(CMD_RESTART, 16'sd0, 24'sd0);
        send_tick(CMD_ADVANCE, SPEED_MIN, 24'sd0);
        send_tick(CMD_ADVANCE, SPEED_MAX, 24'sd256);
        // step that reaches the limit, then an ignored tick and a restart
        send_tick(CMD_ADVANCE, SPEED_MIN, TURN_MIN);
        send_tick(CMD_ADVANCE, SPEED_MAX, TURN_MAX);
        send_tick(CMD_RESTART, SPEED_MIN, TURN_MIN);

        // zero step limit ignores every advance; heading just past the fold
        load_setup(16'd0, 16'd0, 32'h0000_0000, 32'h7FFF_FFFF, 16'hBFFF);
        send_tick(CMD_RESTART, 16'sd0, 24'sd0);
        send_tick(CMD_ADVANCE, SPEED_MAX, TURN_MAX);

        // zero time step still counts steps
        load_setup(16'd0, 16'd2, 32'h0000_0000, 32'h7FFF_FFFF, 16'hBFFF);
        send_tick(CMD_ADVANCE, SPEED_MAX, TURN_MAX);
        send_tick(CMD_ADVANCE, SPEED_MIN, TURN_MIN);
        send_tick(CMD_ADVANCE, SPEED_MAX, TURN_MAX);

        // smallest time step, heading at a half turn
        load_setup(16'd1, 16'hFFFF, 32'h8000_0000, 32'h0000_0000, 16'h8000);
        send_tick(CMD_RESTART, 16'sd0, 24'sd0);
        send_tick(CMD_ADVANCE, SPEED_MAX, TURN_MAX);
        send_tick(CMD_ADVANCE, SPEED_MIN, TURN_MIN);

        // random runs: restart, then mostly advances with some restarts
        n_sent = 0;
        while (n_sent < RANDOM_ITEMS) begin
            load_setup(pick_step(), pick_limit(), pick_pos(), pick_pos(), 16'($urandom));
            send_tick(CMD_RESTART, pick_speed(), pick_turn());
            n_sent++;
            n_ticks = $urandom_range(10, 80);
            repeat (n_ticks) begin
                if ($urandom_range(0, 24) == 0) begin
                    send_tick(CMD_RESTART, pick_speed(), pick_turn());
                end else begin
                    send_tick(CMD_ADVANCE, pick_speed(), pick_turn());
                end
                n_sent++;
            end
        end

        drain();
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
